FILE: rtl/rrs_pkg.sv
package rrs_pkg;

	// Sequence space and window limits of the link.
	localparam int SEQ_SPACE   = 256;
	localparam int SEQ_W       = $clog2(SEQ_SPACE);
	localparam int MAX_WINDOW  = 32;
	localparam int MAX_RESULTS = 33;
	localparam int TAG_W       = 8;
	localparam int WIN_W       = 6;
	localparam int CNT_W       = 32;
	localparam int NRES_W      = 6;

	// Reset value of the negotiated window register.
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(32);

	// Result kinds.
	localparam logic [2:0] K_DELIVER = 3'd0;
	localparam logic [2:0] K_STATE   = 3'd1;
	localparam logic [2:0] K_DROP    = 3'd2;
	localparam logic [2:0] K_HELD    = 3'd3;
	localparam logic [2:0] K_IGNORE  = 3'd4;
	localparam logic [2:0] K_TX      = 3'd5;

	// Command codes.
	localparam logic CMD_RX = 1'b0;
	localparam logic CMD_TX = 1'b1;

	// Connection state codes.
	localparam logic [1:0] CS_CLOSED   = 2'd0;
	localparam logic [1:0] CS_OPEN     = 2'd1;
	localparam logic [1:0] CS_WAIT_SYN = 2'd2;

	// Outcome of the shared sequence arithmetic unit.
	typedef struct packed {
		logic [SEQ_W-1:0] diff;
		logic             zero;
		logic             lt;
	} seq_cmp_t;

endpackage

FILE: rtl/rrs_ram.sv
module rrs_ram #(
	parameter int WIDTH = rrs_pkg::TAG_W,
	parameter int DEPTH = rrs_pkg::SEQ_SPACE
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: rtl/rrs_seq_unit.sv
module rrs_seq_unit (
	input  logic [rrs_pkg::SEQ_W-1:0] a,
	input  logic [rrs_pkg::SEQ_W-1:0] b,
	input  logic [rrs_pkg::SEQ_W-1:0] lim,
	output rrs_pkg::seq_cmp_t         res
);

	logic [rrs_pkg::SEQ_W-1:0] diff;

	// Modular distance from b to a, compared against a limit.
	assign diff     = a - b;
	assign res.diff = diff;
	assign res.zero = (diff == '0);
	assign res.lt   = (diff < lim);

endmodule

FILE: rtl/reliable_rx_sequencer_top.sv
// Receive sequencer of a reliable datagram link. An item is accepted when start is high
// and busy is low; busy then stays high until the item's last result has been
// registered. Every result appears on the result ports for exactly one cycle with
// res_valid high and must be taken then, since the receiver cannot stall the block.
// A received segment is worked in an acknowledge step, then a classification step,
// both on one shared sequence compare unit; each result beyond the first comes from
// the drain walk, which reads one held buffer tag per cycle from the tag memory and
// stops at 33 results per item. A transmit command or a bad frame ends after the
// acknowledge step. While the block is idle, the status ports show the state after
// the last completed item. The window register is written through cfg_valid/cfg_ready
// while the block is idle; no clearing pass is needed after reset.
module reliable_rx_sequencer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        command,
	input  logic                        frame_ok,
	input  logic                        syn_flag,
	input  logic                        ack_flag,
	input  logic                        null_flag,
	input  logic                        busy_flag,
	input  logic                        reset_flag,
	input  logic [rrs_pkg::SEQ_W-1:0]   ack_number,
	input  logic [rrs_pkg::SEQ_W-1:0]   seq_number,
	input  logic                        has_payload,
	input  logic [1:0]                  conn_state,
	input  logic [rrs_pkg::TAG_W-1:0]   buffer_tag,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rrs_pkg::WIN_W-1:0]   window_size,
	output logic                        res_valid,
	output logic [2:0]                  kind,
	output logic [rrs_pkg::TAG_W-1:0]   out_tag,
	output logic [rrs_pkg::SEQ_W-1:0]   out_seq,
	output logic                        out_null,
	output logic                        last_result,
	output logic [rrs_pkg::WIN_W-1:0]   tx_outstanding,
	output logic                        tx_full,
	output logic                        remote_busy,
	output logic [rrs_pkg::CNT_W-1:0]   remote_busy_count,
	output logic [rrs_pkg::CNT_W-1:0]   drop_count
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ACK   = 4'b0010,
		ST_CLASS = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	localparam logic [rrs_pkg::CNT_W-1:0]  CNT_MAX = '1;
	localparam logic [rrs_pkg::NRES_W-1:0] NRES_LAST = rrs_pkg::NRES_W'(rrs_pkg::MAX_RESULTS);

	state_t state_q;

	// Latched input transaction.
	logic                        command_q;
	logic                        frame_ok_q;
	logic                        syn_flag_q;
	logic                        ack_flag_q;
	logic                        null_flag_q;
	logic                        busy_flag_q;
	logic                        reset_flag_q;
	logic [rrs_pkg::SEQ_W-1:0]   ack_number_q;
	logic [rrs_pkg::SEQ_W-1:0]   seq_number_q;
	logic                        has_payload_q;
	logic [1:0]                  conn_state_q;
	logic [rrs_pkg::TAG_W-1:0]   buffer_tag_q;

	// Link state.
	logic [rrs_pkg::WIN_W-1:0]     window_q;
	logic [rrs_pkg::SEQ_W-1:0]     next_exp_q;
	logic [rrs_pkg::SEQ_W-1:0]     last_acked_q;
	logic [rrs_pkg::WIN_W-1:0]     outstanding_q;
	logic                          remote_busy_q;
	logic [rrs_pkg::CNT_W-1:0]     busy_cnt_q;
	logic [rrs_pkg::CNT_W-1:0]     drops_q;
	logic [rrs_pkg::SEQ_SPACE-1:0] held_valid_q;

	// Drain walk.
	logic [rrs_pkg::SEQ_W-1:0]  cur_addr_q;
	logic                       drop_phase_q;
	logic [rrs_pkg::NRES_W-1:0] nres_q;

	// Result register.
	logic                        res_valid_q;
	logic [2:0]                  kind_q;
	logic [rrs_pkg::TAG_W-1:0]   tag_q;
	logic [rrs_pkg::SEQ_W-1:0]   oseq_q;
	logic                        onull_q;
	logic                        last_q;

	logic [rrs_pkg::WIN_W-1:0]  win_eff;
	logic [rrs_pkg::SEQ_W-1:0]  unit_a;
	logic [rrs_pkg::SEQ_W-1:0]  unit_b;
	logic [rrs_pkg::SEQ_W-1:0]  unit_lim;
	rrs_pkg::seq_cmp_t          cmp;
	logic [rrs_pkg::SEQ_W-1:0]  seq_inc;
	logic [rrs_pkg::SEQ_W-1:0]  cur_inc;
	logic                       hv_seq;
	logic                       hv_seq_inc;
	logic                       hv_cur_inc;
	logic                       linked;
	logic                       data_seg;
	logic                       in_order;
	logic                       in_window;
	logic                       hold_go;
	logic [rrs_pkg::SEQ_W-1:0]  rd_addr;
	logic [rrs_pkg::TAG_W-1:0]  rd_tag;
	logic [rrs_pkg::NRES_W-1:0] nres_inc;
	logic                       drain_last;

	// Effective window: at least one, at most the design maximum.
	always_comb begin
		if (window_q == '0) begin
			win_eff = rrs_pkg::WIN_W'(1);
		end else if ({1'b0, window_q} > (rrs_pkg::WIN_W + 1)'(rrs_pkg::MAX_WINDOW)) begin
			win_eff = rrs_pkg::WIN_W'(rrs_pkg::MAX_WINDOW);
		end else begin
			win_eff = window_q;
		end
	end

	// The shared unit measures the acknowledge distance in the acknowledge step and
	// the sequence distance from the expected number in the classification step.
	always_comb begin
		if (state_q == ST_ACK) begin
			unit_a   = ack_number_q;
			unit_b   = last_acked_q;
			unit_lim = rrs_pkg::SEQ_W'(outstanding_q);
		end else begin
			unit_a   = seq_number_q;
			unit_b   = next_exp_q;
			unit_lim = rrs_pkg::SEQ_W'(win_eff) + rrs_pkg::SEQ_W'(1);
		end
	end

	rrs_seq_unit u_seq_unit (
		.a   (unit_a),
		.b   (unit_b),
		.lim (unit_lim),
		.res (cmp)
	);

	// Lookups into the held-entry valid bits.
	assign seq_inc    = seq_number_q + rrs_pkg::SEQ_W'(1);
	assign cur_inc    = cur_addr_q + rrs_pkg::SEQ_W'(1);
	assign hv_seq     = held_valid_q[seq_number_q];
	assign hv_seq_inc = held_valid_q[seq_inc];
	assign hv_cur_inc = held_valid_q[cur_inc];

	// Segment classification terms.
	assign linked    = (conn_state_q == rrs_pkg::CS_OPEN) ||
	                   (conn_state_q == rrs_pkg::CS_WAIT_SYN);
	assign data_seg  = (conn_state_q == rrs_pkg::CS_OPEN) && (null_flag_q || has_payload_q);
	assign in_order  = cmp.zero;
	assign in_window = !cmp.zero && cmp.lt;
	assign hold_go   = (state_q == ST_CLASS) && !reset_flag_q && !syn_flag_q && data_seg &&
	                   !in_order && !hv_seq && in_window;

	// Tag read address is the entry handled in the following drain cycle.
	assign rd_addr = (state_q == ST_CLASS) ? (hv_seq ? seq_number_q : seq_inc) : cur_inc;

	rrs_ram #(
		.WIDTH (rrs_pkg::TAG_W),
		.DEPTH (rrs_pkg::SEQ_SPACE)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (hold_go),
		.wr_addr (seq_number_q),
		.wr_data (buffer_tag_q),
		.rd_addr (rd_addr),
		.rd_data (rd_tag)
	);

	assign nres_inc   = nres_q + rrs_pkg::NRES_W'(1);
	assign drain_last = (nres_inc == NRES_LAST) || !hv_cur_inc;

	// Input latch; payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			command_q     <= command;
			frame_ok_q    <= frame_ok;
			syn_flag_q    <= syn_flag;
			ack_flag_q    <= ack_flag;
			null_flag_q   <= null_flag;
			busy_flag_q   <= busy_flag;
			reset_flag_q  <= reset_flag;
			ack_number_q  <= ack_number;
			seq_number_q  <= seq_number;
			has_payload_q <= has_payload;
			conn_state_q  <= conn_state;
			buffer_tag_q  <= buffer_tag;
		end
	end

	// Sequencer and link state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_q      <= rrs_pkg::WINDOW_RESET;
			next_exp_q    <= '0;
			last_acked_q  <= '0;
			outstanding_q <= '0;
			remote_busy_q <= 1'b0;
			busy_cnt_q    <= '0;
			drops_q       <= '0;
			held_valid_q  <= '0;
			cur_addr_q    <= '0;
			drop_phase_q  <= 1'b0;
			nres_q        <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				window_q <= window_size;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					if (command_q == rrs_pkg::CMD_TX) begin
						if (outstanding_q < win_eff) begin
							outstanding_q <= outstanding_q + rrs_pkg::WIN_W'(1);
						end
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else if (!frame_ok_q) begin
						if (drops_q != CNT_MAX) begin
							drops_q <= drops_q + rrs_pkg::CNT_W'(1);
						end
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						// Release acknowledged transmit slots.
						if (ack_flag_q && !cmp.zero) begin
							outstanding_q <= cmp.lt ?
							                 outstanding_q - cmp.diff[rrs_pkg::WIN_W-1:0] : '0;
							last_acked_q  <= ack_number_q;
						end
						// Count not-busy to busy transitions of the remote side.
						if (!remote_busy_q && busy_flag_q && busy_cnt_q != CNT_MAX) begin
							busy_cnt_q <= busy_cnt_q + rrs_pkg::CNT_W'(1);
						end
						remote_busy_q <= busy_flag_q;
						state_q       <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
					if (!reset_flag_q && syn_flag_q && linked) begin
						next_exp_q <= seq_inc;
					end else if (!reset_flag_q && !syn_flag_q && data_seg) begin
						if (in_order) begin
							next_exp_q <= seq_inc;
							if (hv_seq && drops_q != CNT_MAX) begin
								drops_q <= drops_q + rrs_pkg::CNT_W'(1);
							end
							if (hv_seq || hv_seq_inc) begin
								cur_addr_q   <= hv_seq ? seq_number_q : seq_inc;
								drop_phase_q <= hv_seq;
								nres_q       <= rrs_pkg::NRES_W'(1);
								state_q      <= ST_DRAIN;
							end
						end else if (hv_seq || !in_window) begin
							if (drops_q != CNT_MAX) begin
								drops_q <= drops_q + rrs_pkg::CNT_W'(1);
							end
						end else begin
							held_valid_q[seq_number_q] <= 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					// One held entry per cycle: the stale copy first, then in-order ones.
					res_valid_q              <= 1'b1;
					held_valid_q[cur_addr_q] <= 1'b0;
					if (!drop_phase_q) begin
						next_exp_q <= cur_inc;
					end
					if (drain_last) begin
						state_q <= ST_IDLE;
					end else begin
						cur_addr_q   <= cur_inc;
						drop_phase_q <= 1'b0;
						nres_q       <= nres_inc;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_ACK: begin
				tag_q   <= (command_q == rrs_pkg::CMD_TX) ? '0 : buffer_tag_q;
				oseq_q  <= (command_q == rrs_pkg::CMD_TX) ? '0 : seq_number_q;
				onull_q <= 1'b0;
				last_q  <= 1'b1;
				kind_q  <= (command_q == rrs_pkg::CMD_TX) ? rrs_pkg::K_TX : rrs_pkg::K_DROP;
			end
			ST_CLASS: begin
				tag_q   <= buffer_tag_q;
				oseq_q  <= seq_number_q;
				onull_q <= 1'b0;
				last_q  <= 1'b1;
				if (reset_flag_q) begin
					kind_q <= linked ? rrs_pkg::K_STATE : rrs_pkg::K_IGNORE;
				end else if (syn_flag_q) begin
					kind_q <= linked ? rrs_pkg::K_STATE : rrs_pkg::K_IGNORE;
				end else if (data_seg) begin
					if (in_order) begin
						kind_q  <= rrs_pkg::K_DELIVER;
						onull_q <= null_flag_q;
						last_q  <= !(hv_seq || hv_seq_inc);
					end else if (hv_seq || !in_window) begin
						kind_q <= rrs_pkg::K_DROP;
					end else begin
						kind_q <= rrs_pkg::K_HELD;
					end
				end else begin
					kind_q <= rrs_pkg::K_IGNORE;
				end
			end
			ST_DRAIN: begin
				kind_q  <= drop_phase_q ? rrs_pkg::K_DROP : rrs_pkg::K_DELIVER;
				tag_q   <= rd_tag;
				oseq_q  <= cur_addr_q;
				onull_q <= 1'b0;
				last_q  <= drain_last;
			end
			default: begin
				kind_q <= kind_q;
			end
		endcase
	end

	// Port drive.
	assign busy              = (state_q != ST_IDLE);
	assign cfg_ready         = !busy;
	assign res_valid         = res_valid_q;
	assign kind              = kind_q;
	assign out_tag           = tag_q;
	assign out_seq           = oseq_q;
	assign out_null          = onull_q;
	assign last_result       = last_q;
	assign tx_outstanding    = outstanding_q;
	assign tx_full           = (outstanding_q >= win_eff);
	assign remote_busy       = remote_busy_q;
	assign remote_busy_count = busy_cnt_q;
	assign drop_count        = drops_q;

endmodule

FILE: rtl/rrs_checker.sv
module rrs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       res_valid,
	input logic [2:0] kind,
	input logic       last_result
);

	// An accepted transaction keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// The final result of a transaction is shown once the block is idle again.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last_result |-> !busy)
		else $error("final result shown while still busy");

	// A result that is not the final one is shown while the block is still busy.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last_result |-> busy)
		else $error("intermediate result shown while idle");

	// A held, transmit or ignored result is always marked as the final result of its transaction.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == rrs_pkg::K_HELD || kind == rrs_pkg::K_TX ||
		              kind == rrs_pkg::K_IGNORE) |-> last_result)
		else $error("single-result kind not marked final");

endmodule

bind reliable_rx_sequencer_top rrs_checker u_rrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.res_valid   (res_valid),
	.kind        (kind),
	.last_result (last_result)
);

FILE: verif/reliable_rx_sequencer_top_tb.sv
`timescale 1ns / 100ps

module reliable_rx_sequencer_top_tb;
	import rrs_pkg::*;

	// Connection state that the block treats like closed.
	localparam logic [1:0] CS_OTHER = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// One segment header or transmit command as the block takes it.
	typedef struct packed {
		logic             command;
		logic             frame_ok;
		logic             syn;
		logic             ack;
		logic             nul;
		logic             bsy;
		logic             rst;
		logic [SEQ_W-1:0] ack_no;
		logic [SEQ_W-1:0] seq_no;
		logic             payload;
		logic [1:0]       cstate;
		logic [TAG_W-1:0] tag;
	} segment_t;

	// One result with the status snapshot that travels with it.
	typedef struct packed {
		logic [2:0]       kind;
		logic [TAG_W-1:0] tag;
		logic [SEQ_W-1:0] seq;
		logic             nul;
		logic             last;
		logic [WIN_W-1:0] outst;
		logic             full;
		logic             rbusy;
		logic [CNT_W-1:0] bcnt;
		logic [CNT_W-1:0] dcnt;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             command = CMD_RX;
	logic             frame_ok = 1'b0;
	logic             syn_flag = 1'b0;
	logic             ack_flag = 1'b0;
	logic             null_flag = 1'b0;
	logic             busy_flag = 1'b0;
	logic             reset_flag = 1'b0;
	logic [SEQ_W-1:0] ack_number = '0;
	logic [SEQ_W-1:0] seq_number = '0;
	logic             has_payload = 1'b0;
	logic [1:0]       conn_state = CS_CLOSED;
	logic [TAG_W-1:0] buffer_tag = '0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [WIN_W-1:0] window_size = WINDOW_RESET;
	logic             res_valid;
	logic [2:0]       kind;
	logic [TAG_W-1:0] out_tag;
	logic [SEQ_W-1:0] out_seq;
	logic             out_null;
	logic             last_result;
	logic [WIN_W-1:0] tx_outstanding;
	logic             tx_full;
	logic             remote_busy;
	logic [CNT_W-1:0] remote_busy_count;
	logic [CNT_W-1:0] drop_count;

	// Predicted state of the sequencer.
	logic [WIN_W-1:0] win_reg = WINDOW_RESET;
	logic [SEQ_W-1:0] next_seq = '0;
	logic [SEQ_W-1:0] acked_to = '0;
	int unsigned      tx_pending = 0;
	logic             peer_busy = 1'b0;
	logic [CNT_W-1:0] busy_rises = '0;
	logic [CNT_W-1:0] dropped = '0;
	bit               held_v [SEQ_SPACE];
	logic [TAG_W-1:0] held_t [SEQ_SPACE];
	bit               last_ignored;

	outcome_t    awaited[$];
	outcome_t    seen, want;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned idle_pct = 8;

	reliable_rx_sequencer_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.command           (command),
		.frame_ok          (frame_ok),
		.syn_flag          (syn_flag),
		.ack_flag          (ack_flag),
		.null_flag         (null_flag),
		.busy_flag         (busy_flag),
		.reset_flag        (reset_flag),
		.ack_number        (ack_number),
		.seq_number        (seq_number),
		.has_payload       (has_payload),
		.conn_state        (conn_state),
		.buffer_tag        (buffer_tag),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.window_size       (window_size),
		.res_valid         (res_valid),
		.kind              (kind),
		.out_tag           (out_tag),
		.out_seq           (out_seq),
		.out_null          (out_null),
		.last_result       (last_result),
		.tx_outstanding    (tx_outstanding),
		.tx_full           (tx_full),
		.remote_busy       (remote_busy),
		.remote_busy_count (remote_busy_count),
		.drop_count        (drop_count)
	);

	always #1 clk = ~clk;

	// Hard stop in case the block hangs or drops results.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int unsigned eff_window();
		int unsigned w;
		w = win_reg;
		if (w == 0) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		return w;
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic outcome_t outcome(input logic [2:0] k, input logic [TAG_W-1:0] t,
			input logic [SEQ_W-1:0] s, input logic n);
		outcome_t r;
		r = '0;
		r.kind = k;
		r.tag = t;
		r.seq = s;
		r.nul = n;
		return r;
	endfunction

	function automatic string show_outcome(input outcome_t r);
		return $sformatf({"kind=%0d tag=%02h seq=%02h null=%0b last=%0b outst=%0d full=%0b ",
			"rbusy=%0b busy_cnt=%0d drops=%0d"},
			r.kind, r.tag, r.seq, r.nul, r.last, r.outst, r.full, r.rbusy, r.bcnt, r.dcnt);
	endfunction

	function automatic void note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, what);
	endfunction

	// Work out the results of one accepted segment and queue them.
	function automatic void classify_segment(input segment_t s);
		outcome_t         r[$];
		int unsigned      w;
		logic [SEQ_W-1:0] span;
		bit               linked;
		w = eff_window();
		linked = (s.cstate == CS_OPEN) || (s.cstate == CS_WAIT_SYN);
		if (s.command == CMD_TX) begin
			if (tx_pending < w) tx_pending++;
			r.push_back(outcome(K_TX, '0, '0, 1'b0));
		end else if (!s.frame_ok) begin
			dropped = bump(dropped);
			r.push_back(outcome(K_DROP, s.tag, s.seq_no, 1'b0));
		end else begin
			// The cumulative acknowledge frees transmit slots.
			if (s.ack && s.ack_no != acked_to) begin
				span = s.ack_no - acked_to;
				tx_pending = (tx_pending > span) ? tx_pending - span : 0;
				acked_to = s.ack_no;
			end
			if (!peer_busy && s.bsy) busy_rises = bump(busy_rises);
			peer_busy = s.bsy;
			if (s.rst) begin
				r.push_back(outcome(linked ? K_STATE : K_IGNORE, s.tag, s.seq_no, 1'b0));
			end else if (s.syn) begin
				if (linked) begin
					next_seq = s.seq_no + 1'b1;
					r.push_back(outcome(K_STATE, s.tag, s.seq_no, 1'b0));
				end else begin
					r.push_back(outcome(K_IGNORE, s.tag, s.seq_no, 1'b0));
				end
			end else if (s.cstate == CS_OPEN && (s.nul || s.payload)) begin
				if (s.seq_no == next_seq) begin
					// In order: deliver, discard a stale held copy, then drain.
					r.push_back(outcome(K_DELIVER, s.tag, s.seq_no, s.nul));
					next_seq = next_seq + 1'b1;
					if (held_v[s.seq_no]) begin
						dropped = bump(dropped);
						held_v[s.seq_no] = 1'b0;
						r.push_back(outcome(K_DROP, held_t[s.seq_no], s.seq_no, 1'b0));
					end
					while (r.size() < MAX_RESULTS && held_v[next_seq]) begin
						held_v[next_seq] = 1'b0;
						r.push_back(outcome(K_DELIVER, held_t[next_seq], next_seq, 1'b0));
						next_seq = next_seq + 1'b1;
					end
				end else if (held_v[s.seq_no]) begin
					dropped = bump(dropped);
					r.push_back(outcome(K_DROP, s.tag, s.seq_no, 1'b0));
				end else begin
					span = s.seq_no - next_seq;
					if (span >= 1 && span <= w) begin
						held_v[s.seq_no] = 1'b1;
						held_t[s.seq_no] = s.tag;
						r.push_back(outcome(K_HELD, s.tag, s.seq_no, 1'b0));
					end else begin
						dropped = bump(dropped);
						r.push_back(outcome(K_DROP, s.tag, s.seq_no, 1'b0));
					end
				end
			end else begin
				r.push_back(outcome(K_IGNORE, s.tag, s.seq_no, 1'b0));
			end
		end
		// Every result carries the status after the whole segment.
		for (int i = 0; i < r.size(); i++) begin
			r[i].last = (i == r.size() - 1);
			r[i].outst = WIN_W'(tx_pending);
			r[i].full = (tx_pending >= w);
			r[i].rbusy = peer_busy;
			r[i].bcnt = busy_rises;
			r[i].dcnt = dropped;
			awaited.push_back(r[i]);
		end
		last_ignored = (r[0].kind == K_IGNORE);
	endfunction

	// Compare every result strobe against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			seen = '{kind, out_tag, out_seq, out_null, last_result, tx_outstanding, tx_full,
				remote_busy, remote_busy_count, drop_count};
			if (awaited.size() == 0) begin
				note_mismatch({"result with nothing expected: ", show_outcome(seen)});
			end else begin
				want = awaited.pop_front();
				if (seen !== want)
					note_mismatch({"expected ", show_outcome(want), " got ", show_outcome(seen)});
			end
		end
	end

	// Present one segment, hold it until the transaction is taken, then predict it.
	// Start is left high so that a following call can keep it up without a gap.
	task automatic send_segment(input segment_t s);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= s.command;
		frame_ok <= s.frame_ok;
		syn_flag <= s.syn;
		ack_flag <= s.ack;
		null_flag <= s.nul;
		busy_flag <= s.bsy;
		reset_flag <= s.rst;
		ack_number <= s.ack_no;
		seq_number <= s.seq_no;
		has_payload <= s.payload;
		conn_state <= s.cstate;
		buffer_tag <= s.tag;
		do @(posedge clk); while (busy);
		classify_segment(s);
	endtask

	task automatic wait_drained(input int unsigned slack);
		start <= 1'b0;
		while (awaited.size() != 0 || busy) @(posedge clk);
		repeat (slack) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		wait_drained(2);
		cfg_valid <= 1'b1;
		window_size <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_reg = w;
	endtask

	function automatic segment_t rx_segment(input logic [1:0] cs, input logic [SEQ_W-1:0] sq,
			input logic [TAG_W-1:0] t, input logic pl, input logic n);
		segment_t s;
		s = '0;
		s.command = CMD_RX;
		s.frame_ok = 1'b1;
		s.cstate = cs;
		s.seq_no = sq;
		s.tag = t;
		s.payload = pl;
		s.nul = n;
		return s;
	endfunction

	function automatic segment_t noise_segment();
		segment_t s;
		s.command = 1'($urandom);
		s.frame_ok = 1'($urandom);
		s.syn = 1'($urandom);
		s.ack = 1'($urandom);
		s.nul = 1'($urandom);
		s.bsy = 1'($urandom);
		s.rst = 1'($urandom);
		s.ack_no = SEQ_W'($urandom);
		s.seq_no = SEQ_W'($urandom);
		s.payload = 1'($urandom);
		s.cstate = 2'($urandom);
		s.tag = TAG_W'($urandom);
		return s;
	endfunction

	function automatic segment_t tx_segment();
		segment_t s;
		s = noise_segment();
		s.command = CMD_TX;
		return s;
	endfunction

	// Well-formed data segment on an open link with random content.
	function automatic segment_t data_segment(input logic [SEQ_W-1:0] sq);
		segment_t    s;
		int unsigned pick;
		s = rx_segment(CS_OPEN, sq, TAG_W'($urandom), 1'b1, 1'b0);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			s.payload = 1'b0;
			s.nul = 1'b1;
		end else if (pick < 20) begin
			s.nul = 1'b1;
		end else if (pick < 24) begin
			s.payload = 1'b0;
		end
		s.ack_no = SEQ_W'($urandom);
		if ($urandom_range(0, 1) == 1) begin
			s.ack = 1'b1;
			s.ack_no = acked_to + SEQ_W'($urandom_range(0, tx_pending));
		end
		s.bsy = ($urandom_range(0, 99) < 20);
		return s;
	endfunction

	function automatic void shuffle_seqs(ref logic [SEQ_W-1:0] q[$]);
		int unsigned      p;
		logic [SEQ_W-1:0] tmp;
		for (int j = q.size() - 1; j > 0; j--) begin
			p = $urandom_range(0, j);
			tmp = q[j];
			q[j] = q[p];
			q[p] = tmp;
		end
	endfunction

	task automatic test_transmit_count();
		send_segment(tx_segment());
		send_segment(tx_segment());
	endtask

	task automatic test_bad_frame();
		segment_t s;
		s = '1;
		s.command = CMD_RX;
		s.frame_ok = 1'b0;
		send_segment(s);
	endtask

	// Delivery, holding, duplicates and both edges of the receive window.
	task automatic test_reorder_window();
		segment_t s;
		s = rx_segment(CS_OPEN, 8'd0, 8'h00, 1'b1, 1'b0);
		s.ack = 1'b1;
		s.ack_no = 8'd1;
		send_segment(s);
		send_segment(rx_segment(CS_OPEN, 8'd3, 8'hA5, 1'b1, 1'b0));
		send_segment(rx_segment(CS_OPEN, 8'd3, 8'h5A, 1'b1, 1'b0));
		send_segment(rx_segment(CS_OPEN, 8'd2, 8'h11, 1'b0, 1'b1));
		send_segment(rx_segment(CS_OPEN, 8'd1, 8'h22, 1'b1, 1'b0));
		send_segment(rx_segment(CS_OPEN, 8'd3, 8'h33, 1'b1, 1'b0));
		send_segment(rx_segment(CS_OPEN, 8'd36, 8'h44, 1'b1, 1'b0));
		send_segment(rx_segment(CS_OPEN, 8'd37, 8'h55, 1'b1, 1'b0));
	endtask

	task automatic test_remote_busy();
		segment_t s;
		s = rx_segment(CS_OPEN, 8'd4, 8'h66, 1'b0, 1'b1);
		s.bsy = 1'b1;
		send_segment(s);
		s = rx_segment(CS_OPEN, 8'd5, 8'h77, 1'b1, 1'b0);
		s.bsy = 1'b1;
		send_segment(s);
		send_segment(rx_segment(CS_OPEN, 8'd6, 8'h88, 1'b1, 1'b0));
	endtask

	// RST and SYN in a linked and in the closed connection state, and data the block must ignore.
	task automatic test_control_flags();
		segment_t s;
		s = rx_segment(CS_OPEN, 8'd7, 8'h12, 1'b1, 1'b0);
		s.rst = 1'b1;
		send_segment(s);
		s = rx_segment(CS_CLOSED, 8'd7, 8'h13, 1'b1, 1'b0);
		s.rst = 1'b1;
		send_segment(s);
		s = rx_segment(CS_WAIT_SYN, 8'hFE, 8'h14, 1'b0, 1'b0);
		s.syn = 1'b1;
		send_segment(s);
		s = rx_segment(CS_CLOSED, 8'h10, 8'h15, 1'b0, 1'b0);
		s.syn = 1'b1;
		send_segment(s);
		send_segment(rx_segment(CS_CLOSED, 8'hFF, 8'h16, 1'b1, 1'b0));
		send_segment(rx_segment(CS_OTHER, 8'hFF, 8'h17, 1'b1, 1'b0));
		send_segment(rx_segment(CS_OPEN, 8'hFF, 8'h18, 1'b0, 1'b0));
	endtask

	// A SYN moves the next expected sequence onto a held entry, so the delivery
	// also drops the held copy; the acknowledge wraps and clears the slots.
	task automatic test_held_copy();
		segment_t s;
		send_segment(rx_segment(CS_OPEN, 8'd1, 8'h99, 1'b1, 1'b0));
		s = rx_segment(CS_OPEN, 8'd0, 8'h9A, 1'b0, 1'b0);
		s.syn = 1'b1;
		send_segment(s);
		s = rx_segment(CS_OPEN, 8'd1, 8'hBB, 1'b1, 1'b0);
		s.ack = 1'b1;
		s.ack_no = 8'hFF;
		send_segment(s);
	endtask

	// Fill the whole window, then deliver so that the drain hits its result limit
	// and leaves the entry at base + 33 held; the last segment collects that entry's copy.
	task automatic test_drain_limit();
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] order[$];
		segment_t         s;
		base = next_seq;
		for (int j = 1; j <= MAX_WINDOW; j++) order.push_back(base + SEQ_W'(j));
		shuffle_seqs(order);
		for (int j = 0; j < order.size(); j++)
			send_segment(rx_segment(CS_OPEN, order[j], TAG_W'($urandom), 1'b1, 1'b0));
		s = rx_segment(CS_OPEN, base, TAG_W'($urandom), 1'b0, 1'b0);
		s.syn = 1'b1;
		send_segment(s);
		send_segment(rx_segment(CS_OPEN, base + SEQ_W'(33), TAG_W'($urandom), 1'b1, 1'b0));
		send_segment(rx_segment(CS_OPEN, base + 8'd1, TAG_W'($urandom), 1'b1, 1'b0));
		send_segment(rx_segment(CS_OPEN, base + SEQ_W'(33), TAG_W'($urandom), 1'b1, 1'b0));
	endtask

	// Mostly runs of in-window sequences in shuffled order, mixed with transmits,
	// stale and far sequences, and fully random segments.
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned      counted;
		int unsigned      w;
		int unsigned      k;
		logic [SEQ_W-1:0] order[$];
		counted = 0;
		while (counted < n_items) begin
			if ($urandom_range(0, 99) < 20) begin
				send_segment(noise_segment());
				if (!last_ignored) counted++;
			end else begin
				w = eff_window();
				k = $urandom_range(1, (w < 8) ? w : 8);
				order.delete();
				for (int j = 0; j < k; j++) order.push_back(next_seq + SEQ_W'(j));
				if ($urandom_range(0, 9) == 0)
					order.push_back(next_seq + SEQ_W'(w + $urandom_range(1, 20)));
				if ($urandom_range(0, 9) == 0) order.push_back(next_seq - 1'b1);
				shuffle_seqs(order);
				for (int j = 0; j < order.size(); j++) begin
					if ($urandom_range(0, 99) < 12) begin
						send_segment(tx_segment());
						counted++;
					end
					send_segment(data_segment(order[j]));
					if (!last_ignored) counted++;
				end
			end
		end
	endtask

	task automatic test_window_setting(input logic [WIN_W-1:0] w, input int unsigned n_items);
		write_window(w);
		test_random_traffic(n_items);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_transmit_count();
		test_bad_frame();
		test_reorder_window();
		test_remote_busy();
		test_control_flags();
		test_held_copy();
		test_drain_limit();
		// One long stretch with the sender never pausing.
		idle_pct = 0;
		test_random_traffic(20);
		idle_pct = 8;
		test_window_setting(6'd1, 4);
		test_window_setting(6'd63, 4);
		test_window_setting(6'd0, 4);
		test_window_setting(6'd13, 4);
		test_window_setting(6'd32, 4);
		wait_drained(40);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
